// ===== hdl/frpm_pkg.sv =====
// Shared constants for the frame RMS / peak level meter.
package frpm_pkg;

  localparam int MAX_FRAME_SAMPLES = 1024;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 16;
  localparam int PROD_W   = 2 * MAG_W;
  localparam int CNT_W    = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SUM_W    = 2 * (MAG_W - 1) + CNT_W;
  localparam int FRAC_W   = 16;
  localparam int NUM_W    = SUM_W + FRAC_W;
  localparam int ROOT_W   = 24;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int SREM_W   = ROOT_W + 2;
  localparam int STEP_W   = $clog2(NUM_W);
  localparam int PEAK_W   = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  localparam logic [ROOT_W-1:0] RMS_FULL_SCALE = ROOT_W'(8388608);
  localparam logic [PEAK_W-1:0] PEAK_FULL_SCALE = PEAK_W'(32768);

endpackage

// ===== hdl/frame_rms_peak_meter_unit.sv =====
// Frame RMS / peak level meter: bit-serial square, divide and root.
//
// Channel   Dir  tdata (low bit up)                    tuser            tlast
// s_axis    in   sample[15:0]                          has_sample       frame_end
// m_axis    out  rms_level[23:0], peak_level[39:24]    frame_too_long   -
//
// A sample item is taken from the input, then squared by a shift-add loop,
//   one multiplier bit per cycle, plus a final check step.
// A frame end adds a decision step, restoring division (one quotient bit per step)
//   and digit-by-digit square root, both skipped for overlong or empty frames, and a load step.
// Reset clears the frame state and the output valid at once; no clearing pass.
// A finished result sits in the output register; new items are taken meanwhile,
//   and the next frame's result waits in the load state, input stalled, until
//   the consumer takes the first.
module frame_rms_peak_meter_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [frpm_pkg::IN_DATA_W-1:0] s_axis_tdata,   // sample[15:0]
  input  logic                           s_axis_tuser,   // has_sample
  input  logic                           s_axis_tlast,   // frame_end
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [frpm_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // rms_level[23:0], peak_level[39:24]
  output logic                           m_axis_tuser    // frame_too_long
);
  import frpm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIN,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } state_e;

  state_e             state_q, state_d;
  // frame accumulators
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [MAG_W-1:0]   peak_q, peak_d;
  logic [CNT_W-1:0]   total_q, total_d;
  logic               ovl_q, ovl_d;
  logic               last_q, last_d;
  // shift-add squarer
  logic [PROD_W-1:0]  mcand_q, mcand_d;
  logic [MAG_W-1:0]   mplier_q, mplier_d;
  // divider and root
  logic [NUM_W-1:0]   num_q, num_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [RAD_W-1:0]   quot_q, quot_d;
  logic [SREM_W-1:0]  srem_q, srem_d;
  logic [ROOT_W-1:0]  root_q, root_d;
  logic [STEP_W-1:0]  step_q, step_d;
  // output register
  logic               mvalid_q, mvalid_d;
  logic [ROOT_W-1:0]  rms_q, rms_d;
  logic [PEAK_W-1:0]  opeak_q, opeak_d;
  logic               oflag_q, oflag_d;

  logic [MAG_W-1:0]   mag;
  logic [CNT_W:0]     div_sh;
  logic               div_ge;
  logic [CNT_W:0]     div_diff;
  logic [SREM_W+1:0]  sq_sh;
  logic [SREM_W+1:0]  sq_trial;
  logic               sq_ge;
  logic [SREM_W+1:0]  sq_diff;
  logic               room;

  assign mag      = s_axis_tdata[SAMPLE_W-1] ? MAG_W'(~s_axis_tdata + 1'b1)
                                             : MAG_W'(s_axis_tdata);
  assign room     = (total_q != CNT_W'(MAX_FRAME_SAMPLES));
  assign div_sh   = {rem_q, num_q[NUM_W-1]};
  assign div_ge   = (div_sh >= {1'b0, total_q});
  assign div_diff = div_sh - {1'b0, total_q};
  assign sq_sh    = {srem_q, quot_q[RAD_W-1 -: 2]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);
  assign sq_diff  = sq_sh - sq_trial;

  always_comb begin
    state_d  = state_q;
    sum_d    = sum_q;
    peak_d   = peak_q;
    total_d  = total_q;
    ovl_d    = ovl_q;
    last_d   = last_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    num_d    = num_q;
    rem_d    = rem_q;
    quot_d   = quot_q;
    srem_d   = srem_q;
    root_d   = root_q;
    step_d   = step_q;
    mvalid_d = mvalid_q;
    rms_d    = rms_q;
    opeak_d  = opeak_q;
    oflag_d  = oflag_q;

    if (mvalid_q && m_axis_tready) begin
      mvalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          last_d = s_axis_tlast;
          if (s_axis_tuser && room) begin
            if (mag > peak_q) begin
              peak_d = mag;
            end
            total_d  = total_q + 1'b1;
            mcand_d  = PROD_W'(mag);
            mplier_d = mag;
            state_d  = ST_MUL;
          end else begin
            if (s_axis_tuser) begin
              ovl_d = 1'b1;   // sample past the frame limit is dropped
            end
            state_d = s_axis_tlast ? ST_FIN : ST_IDLE;
          end
        end
      end
      ST_MUL: begin
        if (mplier_q == '0) begin
          state_d = last_q ? ST_FIN : ST_IDLE;
        end else begin
          if (mplier_q[0]) begin
            sum_d = sum_q + SUM_W'(mcand_q);
          end
          mcand_d  = mcand_q << 1;
          mplier_d = mplier_q >> 1;
        end
      end
      ST_FIN: begin
        // overlong or empty frames skip the arithmetic
        if (ovl_q || (total_q == '0)) begin
          state_d = ST_OUT;
        end else begin
          num_d   = {sum_q, {FRAC_W{1'b0}}};
          rem_d   = '0;
          quot_d  = '0;
          step_d  = STEP_W'(NUM_W - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = div_ge ? div_diff[CNT_W-1:0] : div_sh[CNT_W-1:0];
        quot_d = {quot_q[RAD_W-2:0], div_ge};
        num_d  = num_q << 1;
        if (step_q == '0) begin
          srem_d  = '0;
          root_d  = '0;
          step_d  = STEP_W'(ROOT_W - 1);
          state_d = ST_SQRT;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_SQRT: begin
        if (sq_ge) begin
          srem_d = sq_diff[SREM_W-1:0];
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          srem_d = sq_sh[SREM_W-1:0];
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        quot_d = quot_q << 2;
        if (step_q == '0) begin
          state_d = ST_OUT;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_OUT: begin
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d = 1'b1;
          if (ovl_q) begin
            rms_d   = '0;
            opeak_d = '0;
            oflag_d = 1'b1;
          end else if (total_q == '0) begin
            rms_d   = '0;
            opeak_d = '0;
            oflag_d = 1'b0;
          end else begin
            rms_d   = (root_q > RMS_FULL_SCALE) ? RMS_FULL_SCALE : root_q;
            opeak_d = PEAK_W'(peak_q);
            oflag_d = 1'b0;
          end
          sum_d   = '0;
          peak_d  = '0;
          total_d = '0;
          ovl_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      sum_q    <= '0;
      peak_q   <= '0;
      total_q  <= '0;
      ovl_q    <= 1'b0;
      last_q   <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sum_q    <= sum_d;
      peak_q   <= peak_d;
      total_q  <= total_d;
      ovl_q    <= ovl_d;
      last_q   <= last_d;
      mvalid_q <= mvalid_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    num_q    <= num_d;
    rem_q    <= rem_d;
    quot_q   <= quot_d;
    srem_q   <= srem_d;
    root_q   <= root_d;
    step_q   <= step_d;
    rms_q    <= rms_d;
    opeak_q  <= opeak_d;
    oflag_q  <= oflag_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {opeak_q, rms_q};
  assign m_axis_tuser  = oflag_q;

  // an overlong frame reports zero levels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mvalid_q && oflag_q) |-> (rms_q == '0 && opeak_q == '0))
    else $error("overlong frame result carries nonzero levels");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mvalid_q |-> (rms_q <= RMS_FULL_SCALE && opeak_q <= PEAK_FULL_SCALE))
    else $error("result level above full scale");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(MAX_FRAME_SAMPLES))
    else $error("sample count beyond frame limit");

  // a waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mvalid_q && !m_axis_tready) |=> (mvalid_q && $stable(rms_q) && $stable(opeak_q)))
    else $error("pending result changed before it was taken");

endmodule
